FILE: src/gfja_pkg.sv
`timescale 1ns / 1ps

package gfja_pkg;

    localparam int FRAC_BITS   = 32;
    localparam int RSQRT_ITERS = 4;

    localparam int POS_W  = 48;
    localparam int DIFF_W = POS_W + 1;
    localparam int MASS_W = 47;
    localparam int SUM_W  = 64;
    localparam int C_W    = 30;
    localparam int MC_W   = MASS_W + C_W;
    localparam int H_W    = 6;
    localparam int E_W    = 9;

    localparam int MUL_A_W = 96;
    localparam int MUL_B_W = 64;
    localparam int MUL_P_W = 128;

    localparam int IN_DATA_W  = 336;
    localparam int OUT_DATA_W = 384;

    localparam logic [31:0] SEED_X_LOW  = 32'd1803886264;
    localparam logic [31:0] SEED_X_HIGH = 32'd1288490188;
    localparam logic [63:0] THREE_Q31   = 64'h0000_0001_8000_0000;
    localparam logic [63:0] S64_MAX     = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] S64_MIN     = 64'h8000_0000_0000_0000;
    localparam logic [H_W-1:0] H_START  = H_W'(31);
    localparam logic signed [E_W-1:0] E_BASE = E_W'(2 * FRAC_BITS - 28);

    typedef enum logic {
        FUNC_LOAD     = 1'b0,
        FUNC_INTERACT = 1'b1
    } func_t;

    typedef enum logic [4:0] {
        SQ_IDLE,
        SQ_R2,
        SQ_NORM,
        SQ_NR_Y2,
        SQ_NR_T,
        SQ_NR_Y,
        SQ_C_Y2,
        SQ_C_Y3,
        SQ_U,
        SQ_D,
        SQ_UV3,
        SQ_W,
        SQ_MC,
        SQ_ACC_MUL,
        SQ_ACC_ADD,
        SQ_JRK_MUL,
        SQ_JRK_ADD,
        SQ_OUT
    } seq_state_t;

    typedef enum logic [2:0] {
        MS_IDLE,
        MS_PROD,
        MS_DRAIN,
        MS_SIGN,
        MS_DONE
    } mul_state_t;

    typedef struct packed {
        logic               start;
        logic [MUL_A_W-1:0] a;
        logic [MUL_B_W-1:0] b;
    } mul_req_t;

    typedef struct packed {
        logic               done;
        logic [MUL_P_W-1:0] p;
    } mul_rsp_t;

    function automatic logic [63:0] clamp64(input logic [127:0] a);
        if (a[127:63] == '0 || a[127:63] == '1) begin
            return a[63:0];
        end
        return a[127] ? S64_MIN : S64_MAX;
    endfunction

    function automatic logic [63:0] addsat64(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] s;
        s = a + b;
        if (a[63] == b[63] && s[63] != a[63]) begin
            return a[63] ? S64_MIN : S64_MAX;
        end
        return s;
    endfunction

    // multiply by 2^e: floor on the way down, saturate on the way up
    function automatic logic [63:0] scale_pow2(input logic [127:0] a,
                                               input logic signed [E_W-1:0] e);
        logic [127:0]   sh;
        logic [63:0]    v;
        logic [E_W-1:0] n;
        begin
            v = clamp64(a);
            n = E_W'(-e);
            if (e < 0) begin
                if (n >= E_W'(128)) begin
                    sh = {128{a[127]}};
                end else begin
                    sh = $signed(a) >>> n[6:0];
                end
                return clamp64(sh);
            end
            if (e == 0 || v == '0) begin
                return v;
            end
            if (e >= 64) begin
                return v[63] ? S64_MIN : S64_MAX;
            end
            sh = {{64{v[63]}}, v} << e[5:0];
            return clamp64(sh);
        end
    endfunction

endpackage

FILE: src/gfja_mul.sv
`timescale 1ns / 1ps

module gfja_mul (
    input  logic               aclk,
    input  logic               aresetn,
    input  gfja_pkg::mul_req_t req,
    output gfja_pkg::mul_rsp_t rsp
);

    localparam logic [2:0] LAST_DIG = 3'd5;  // 3 x 2 digits of 32 bits

    gfja_pkg::mul_state_t state_reg, state_next;

    logic [gfja_pkg::MUL_A_W-1:0] amag_reg;
    logic [gfja_pkg::MUL_B_W-1:0] bmag_reg;
    logic                         neg_reg;
    logic [2:0]                   dig_reg;
    logic [63:0]                  pp_reg;
    logic [1:0]                   ppsh_reg;
    logic [gfja_pkg::MUL_P_W-1:0] acc_reg;
    logic [gfja_pkg::MUL_P_W-1:0] p_reg;

    logic load_en, pp_en, acc_en, sign_en;
    logic [gfja_pkg::MUL_P_W-1:0] pp_shifted;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            gfja_pkg::MS_IDLE:  if (req.start) state_next = gfja_pkg::MS_PROD;
            gfja_pkg::MS_PROD:  if (dig_reg == LAST_DIG) state_next = gfja_pkg::MS_DRAIN;
            gfja_pkg::MS_DRAIN: state_next = gfja_pkg::MS_SIGN;
            gfja_pkg::MS_SIGN:  state_next = gfja_pkg::MS_DONE;
            gfja_pkg::MS_DONE:  state_next = gfja_pkg::MS_IDLE;
            default:            state_next = gfja_pkg::MS_IDLE;
        endcase
    end

    always_comb begin
        load_en  = 1'b0;
        pp_en    = 1'b0;
        acc_en   = 1'b0;
        sign_en  = 1'b0;
        rsp.done = 1'b0;
        rsp.p    = p_reg;
        case (state_reg)
            gfja_pkg::MS_IDLE: load_en = req.start;
            gfja_pkg::MS_PROD: begin
                pp_en  = 1'b1;
                acc_en = (dig_reg != 3'd0);
            end
            gfja_pkg::MS_DRAIN: acc_en = 1'b1;
            gfja_pkg::MS_SIGN:  sign_en = 1'b1;
            gfja_pkg::MS_DONE:  rsp.done = 1'b1;
            default: ;
        endcase
    end

    assign pp_shifted = {64'd0, pp_reg} << {ppsh_reg, 5'd0};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= gfja_pkg::MS_IDLE;
            dig_reg   <= 3'd0;
        end else begin
            state_reg <= state_next;
            if (load_en) begin
                dig_reg <= 3'd0;
            end else if (pp_en) begin
                dig_reg <= dig_reg + 3'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load_en) begin
            amag_reg <= req.a[gfja_pkg::MUL_A_W-1] ? -req.a : req.a;
            bmag_reg <= req.b[gfja_pkg::MUL_B_W-1] ? -req.b : req.b;
            neg_reg  <= req.a[gfja_pkg::MUL_A_W-1] ^ req.b[gfja_pkg::MUL_B_W-1];
            acc_reg  <= '0;
        end else if (acc_en) begin
            acc_reg <= acc_reg + pp_shifted;
        end
        if (pp_en) begin
            pp_reg   <= amag_reg[{dig_reg[2:1], 5'd0} +: 32] * bmag_reg[{dig_reg[0], 5'd0} +: 32];
            ppsh_reg <= dig_reg[2:1] + {1'b0, dig_reg[0]};
        end
        if (sign_en) begin
            p_reg <= neg_reg ? -acc_reg : acc_reg;
        end
    end

endmodule

FILE: src/gfja_core.sv
`timescale 1ns / 1ps

module gfja_core #(
    parameter int RSQRT_ITERS = gfja_pkg::RSQRT_ITERS
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic                                 in_func,
    input  logic [2:0][gfja_pkg::POS_W-1:0]      in_pos,
    input  logic [2:0][gfja_pkg::POS_W-1:0]      in_vel,
    input  logic [gfja_pkg::MASS_W-1:0]          in_mass,
    output logic                                 res_valid,
    input  logic                                 res_ready,
    output logic [2:0][gfja_pkg::SUM_W-1:0]      res_acc,
    output logic [2:0][gfja_pkg::SUM_W-1:0]      res_jerk,
    output logic                                 res_singular,
    output gfja_pkg::mul_req_t                   mul_req,
    input  gfja_pkg::mul_rsp_t                   mul_rsp
);

    localparam int IT_W = $clog2(RSQRT_ITERS);
    localparam logic [IT_W-1:0] IT_LAST = IT_W'(RSQRT_ITERS - 1);
    localparam logic [1:0] K_LAST = 2'd2;
    localparam logic [gfja_pkg::H_W-1:0] H_STEP = 1;

    gfja_pkg::seq_state_t state_reg, state_next;

    logic            issued_reg;
    logic [1:0]      k_reg;
    logic [IT_W-1:0] it_reg;

    logic [2:0][gfja_pkg::POS_W-1:0]  tpos_reg, tvel_reg;
    logic [2:0][gfja_pkg::SUM_W-1:0]  acc_reg, jerk_reg;
    logic [2:0][gfja_pkg::DIFF_W-1:0] r_reg, v_reg;
    logic [2:0][63:0]                 u_reg, w_reg;
    logic [gfja_pkg::MASS_W-1:0]      m_reg;
    logic [127:0]                     wide_reg;
    logic [gfja_pkg::H_W-1:0]         h_reg;
    logic [63:0]                      x_reg;
    logic [31:0]                      y_reg;
    logic [63:0]                      tmp_reg;
    logic [gfja_pkg::C_W-1:0]         c_reg;
    logic [63:0]                      uv3_reg;
    logic [gfja_pkg::MC_W-1:0]        mc_reg;
    logic [63:0]                      inc_reg;
    logic                             sing_reg;

    logic                           accept;
    logic                           mul_state;
    logic                           done;
    logic [gfja_pkg::DIFF_W-1:0]    r_k, v_k;
    logic [63:0]                    nr_t;
    logic [63:0]                    d_shift;
    logic [6:0]                     u_sh;
    logic [7:0]                     h3;
    logic signed [gfja_pkg::E_W-1:0] e_exp;

    assign accept   = in_valid && in_ready;
    assign done     = mul_rsp.done;
    assign r_k      = r_reg[k_reg];
    assign v_k      = v_reg[k_reg];
    assign nr_t     = mul_rsp.p[63:0] >> 31;
    assign d_shift  = 64'($signed(wide_reg) >>> 30);
    assign u_sh     = {1'b0, h_reg} + 7'd1;
    assign h3       = {1'b0, h_reg, 1'b0} + {2'b00, h_reg};
    assign e_exp    = gfja_pkg::E_BASE - $signed({1'b0, h3});

    assign res_acc      = acc_reg;
    assign res_jerk     = jerk_reg;
    assign res_singular = sing_reg;

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            gfja_pkg::SQ_IDLE:
                if (accept && in_func == gfja_pkg::FUNC_INTERACT) state_next = gfja_pkg::SQ_R2;
            gfja_pkg::SQ_R2:
                if (done && k_reg == K_LAST) state_next = gfja_pkg::SQ_NORM;
            gfja_pkg::SQ_NORM:
                if (wide_reg == '0) begin
                    state_next = gfja_pkg::SQ_OUT;
                end else if (wide_reg[127:64] == '0 && wide_reg[63:62] != 2'b00) begin
                    state_next = gfja_pkg::SQ_NR_Y2;
                end
            gfja_pkg::SQ_NR_Y2: if (done) state_next = gfja_pkg::SQ_NR_T;
            gfja_pkg::SQ_NR_T:  if (done) state_next = gfja_pkg::SQ_NR_Y;
            gfja_pkg::SQ_NR_Y:
                if (done) state_next = (it_reg == IT_LAST) ? gfja_pkg::SQ_C_Y2 : gfja_pkg::SQ_NR_Y2;
            gfja_pkg::SQ_C_Y2:  if (done) state_next = gfja_pkg::SQ_C_Y3;
            gfja_pkg::SQ_C_Y3:  if (done) state_next = gfja_pkg::SQ_U;
            gfja_pkg::SQ_U:     if (done && k_reg == K_LAST) state_next = gfja_pkg::SQ_D;
            gfja_pkg::SQ_D:     if (done && k_reg == K_LAST) state_next = gfja_pkg::SQ_UV3;
            gfja_pkg::SQ_UV3:   state_next = gfja_pkg::SQ_W;
            gfja_pkg::SQ_W:     if (done && k_reg == K_LAST) state_next = gfja_pkg::SQ_MC;
            gfja_pkg::SQ_MC:    if (done) state_next = gfja_pkg::SQ_ACC_MUL;
            gfja_pkg::SQ_ACC_MUL: if (done) state_next = gfja_pkg::SQ_ACC_ADD;
            gfja_pkg::SQ_ACC_ADD: state_next = gfja_pkg::SQ_JRK_MUL;
            gfja_pkg::SQ_JRK_MUL: if (done) state_next = gfja_pkg::SQ_JRK_ADD;
            gfja_pkg::SQ_JRK_ADD:
                state_next = (k_reg == K_LAST) ? gfja_pkg::SQ_OUT : gfja_pkg::SQ_ACC_MUL;
            gfja_pkg::SQ_OUT:   if (res_ready) state_next = gfja_pkg::SQ_IDLE;
            default:            state_next = gfja_pkg::SQ_IDLE;
        endcase
    end

    // outputs and multiplier operand selection
    always_comb begin
        in_ready  = 1'b0;
        res_valid = 1'b0;
        mul_state = 1'b0;
        mul_req.a = '0;
        mul_req.b = '0;
        case (state_reg)
            gfja_pkg::SQ_IDLE: in_ready = 1'b1;
            gfja_pkg::SQ_R2: begin
                mul_state = 1'b1;
                mul_req.a = {{47{r_k[48]}}, r_k};
                mul_req.b = {{15{r_k[48]}}, r_k};
            end
            gfja_pkg::SQ_NR_Y2, gfja_pkg::SQ_C_Y2: begin
                mul_state = 1'b1;
                mul_req.a = {64'd0, y_reg};
                mul_req.b = {32'd0, y_reg};
            end
            gfja_pkg::SQ_NR_T: begin
                mul_state = 1'b1;
                mul_req.a = {63'd0, x_reg[63:31]};
                mul_req.b = tmp_reg;
            end
            gfja_pkg::SQ_NR_Y: begin
                mul_state = 1'b1;
                mul_req.a = {64'd0, y_reg};
                mul_req.b = tmp_reg;
            end
            gfja_pkg::SQ_C_Y3: begin
                mul_state = 1'b1;
                mul_req.a = {32'd0, tmp_reg};
                mul_req.b = {32'd0, y_reg};
            end
            gfja_pkg::SQ_U: begin
                mul_state = 1'b1;
                mul_req.a = {{47{r_k[48]}}, r_k};
                mul_req.b = {32'd0, y_reg};
            end
            gfja_pkg::SQ_D: begin
                mul_state = 1'b1;
                mul_req.a = {{32{u_reg[k_reg][63]}}, u_reg[k_reg]};
                mul_req.b = {{15{v_k[48]}}, v_k};
            end
            gfja_pkg::SQ_W: begin
                mul_state = 1'b1;
                mul_req.a = {{32{uv3_reg[63]}}, uv3_reg};
                mul_req.b = u_reg[k_reg];
            end
            gfja_pkg::SQ_MC: begin
                mul_state = 1'b1;
                mul_req.a = {49'd0, m_reg};
                mul_req.b = {34'd0, c_reg};
            end
            gfja_pkg::SQ_ACC_MUL: begin
                mul_state = 1'b1;
                mul_req.a = {19'd0, mc_reg};
                mul_req.b = {{15{r_k[48]}}, r_k};
            end
            gfja_pkg::SQ_JRK_MUL: begin
                mul_state = 1'b1;
                mul_req.a = {19'd0, mc_reg};
                mul_req.b = w_reg[k_reg];
            end
            gfja_pkg::SQ_OUT: res_valid = 1'b1;
            default: ;
        endcase
        mul_req.start = mul_state && !issued_reg;
    end

    // control and architectural state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= gfja_pkg::SQ_IDLE;
            issued_reg <= 1'b0;
            k_reg      <= 2'd0;
            it_reg     <= '0;
            tpos_reg   <= '0;
            tvel_reg   <= '0;
            acc_reg    <= '0;
            jerk_reg   <= '0;
        end else begin
            state_reg <= state_next;
            if (mul_req.start) begin
                issued_reg <= 1'b1;
            end else if (done) begin
                issued_reg <= 1'b0;
            end

            case (state_reg)
                gfja_pkg::SQ_IDLE: begin
                    k_reg <= 2'd0;
                    if (accept && in_func == gfja_pkg::FUNC_LOAD) begin
                        tpos_reg <= in_pos;
                        tvel_reg <= in_vel;
                        acc_reg  <= '0;
                        jerk_reg <= '0;
                    end
                end
                gfja_pkg::SQ_R2, gfja_pkg::SQ_U, gfja_pkg::SQ_D, gfja_pkg::SQ_W:
                    if (done) k_reg <= (k_reg == K_LAST) ? 2'd0 : k_reg + 2'd1;
                gfja_pkg::SQ_NORM:
                    it_reg <= '0;
                gfja_pkg::SQ_NR_Y:
                    if (done) it_reg <= it_reg + IT_W'(1);
                gfja_pkg::SQ_ACC_ADD:
                    acc_reg[k_reg] <= gfja_pkg::addsat64(acc_reg[k_reg], inc_reg);
                gfja_pkg::SQ_JRK_ADD: begin
                    jerk_reg[k_reg] <= gfja_pkg::addsat64(jerk_reg[k_reg], inc_reg);
                    k_reg <= (k_reg == K_LAST) ? 2'd0 : k_reg + 2'd1;
                end
                default: ;
            endcase
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        case (state_reg)
            gfja_pkg::SQ_IDLE:
                if (accept) begin
                    for (int i = 0; i < 3; i++) begin
                        r_reg[i] <= {in_pos[i][47], in_pos[i]} - {tpos_reg[i][47], tpos_reg[i]};
                        v_reg[i] <= {in_vel[i][47], in_vel[i]} - {tvel_reg[i][47], tvel_reg[i]};
                    end
                    m_reg    <= in_mass;
                    wide_reg <= '0;
                    h_reg    <= gfja_pkg::H_START;
                    sing_reg <= 1'b0;
                end
            gfja_pkg::SQ_R2:
                if (done) wide_reg <= wide_reg + mul_rsp.p;
            gfja_pkg::SQ_NORM:
                // even shifts until the square sits in [2^62, 2^64)
                if (wide_reg == '0) begin
                    sing_reg <= 1'b1;
                end else if (wide_reg[127:64] != '0) begin
                    wide_reg <= wide_reg >> 2;
                    h_reg    <= h_reg + H_STEP;
                end else if (wide_reg[63:62] == 2'b00) begin
                    wide_reg <= wide_reg << 2;
                    h_reg    <= h_reg - H_STEP;
                end else begin
                    x_reg    <= wide_reg[63:0];
                    y_reg    <= wide_reg[63] ? gfja_pkg::SEED_X_HIGH : gfja_pkg::SEED_X_LOW;
                    wide_reg <= '0;
                end
            gfja_pkg::SQ_NR_Y2, gfja_pkg::SQ_C_Y2:
                if (done) tmp_reg <= mul_rsp.p[63:0] >> 31;
            gfja_pkg::SQ_NR_T:
                if (done) tmp_reg <= (nr_t >= gfja_pkg::THREE_Q31) ? 64'd0
                                                                    : gfja_pkg::THREE_Q31 - nr_t;
            gfja_pkg::SQ_NR_Y:
                if (done) y_reg <= mul_rsp.p[63:32];
            gfja_pkg::SQ_C_Y3:
                if (done) c_reg <= mul_rsp.p[63:34];
            gfja_pkg::SQ_U:
                if (done) u_reg[k_reg] <= 64'($signed(mul_rsp.p) >>> u_sh);
            gfja_pkg::SQ_D:
                if (done) wide_reg <= wide_reg + mul_rsp.p;
            gfja_pkg::SQ_UV3:
                uv3_reg <= d_shift + {d_shift[62:0], 1'b0};
            gfja_pkg::SQ_W:
                if (done) w_reg[k_reg] <= {{15{v_k[48]}}, v_k} - 64'($signed(mul_rsp.p) >>> 30);
            gfja_pkg::SQ_MC:
                if (done) mc_reg <= mul_rsp.p[gfja_pkg::MC_W-1:0];
            gfja_pkg::SQ_ACC_MUL, gfja_pkg::SQ_JRK_MUL:
                if (done) inc_reg <= gfja_pkg::scale_pow2(mul_rsp.p, e_exp);
            default: ;
        endcase
    end

endmodule

FILE: src/gravity_force_jerk_accumulator_top.sv
`timescale 1ns / 1ps

// Hermite gravity accumulator for one target body.
// Input channel s_*: a load transaction (s_tuser = 0) stores the target's
// position and velocity and clears the acceleration and jerk sums; it gives
// no result. An interact transaction (s_tuser = 1) adds the pull of one
// source body and returns all six sums on m_*, with m_tuser = 1 when the
// separation was zero and the sums were left alone.
// Interact products run one at a time through the shared 32x32 multiplier:
// 21 + 3*RSQRT_ITERS products, plus one normalising step per two-bit
// shift of |r|^2 (up to 31 shifts). A zero-separation item skips to the
// result after the |r|^2 products. s_tready is high only while the
// sequencer is idle, one item at a time.
// The result sits in an output register, so the next item is taken while
// m_tvalid waits for m_tready; a stalled result holds the sequencer at its
// final step until the register frees up.
// Reset clears the target body, the sums and all control state.

module gravity_force_jerk_accumulator_top #(
    parameter int RSQRT_ITERS = gfja_pkg::RSQRT_ITERS
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, mass, one zero pad bit
    input  logic [gfja_pkg::IN_DATA_W-1:0]      s_tdata,
    // func
    input  logic [0:0]                          s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // acc_x, acc_y, acc_z, jerk_x, jerk_y, jerk_z
    output logic [gfja_pkg::OUT_DATA_W-1:0]     m_tdata,
    // singular
    output logic [0:0]                          m_tuser
);

    logic [2:0][gfja_pkg::POS_W-1:0] in_pos, in_vel;
    logic [2:0][gfja_pkg::SUM_W-1:0] res_acc, res_jerk;
    logic res_valid, res_ready, res_singular;

    gfja_pkg::mul_req_t mul_req;
    gfja_pkg::mul_rsp_t mul_rsp;

    logic                              m_valid_reg, m_valid_next;
    logic [gfja_pkg::OUT_DATA_W-1:0]   m_data_reg;
    logic                              m_user_reg;

    assign in_pos = s_tdata[143:0];
    assign in_vel = s_tdata[287:144];

    gfja_core #(
        .RSQRT_ITERS (RSQRT_ITERS)
    ) u_core (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_valid     (s_tvalid),
        .in_ready     (s_tready),
        .in_func      (s_tuser[0]),
        .in_pos       (in_pos),
        .in_vel       (in_vel),
        .in_mass      (s_tdata[334:288]),
        .res_valid    (res_valid),
        .res_ready    (res_ready),
        .res_acc      (res_acc),
        .res_jerk     (res_jerk),
        .res_singular (res_singular),
        .mul_req      (mul_req),
        .mul_rsp      (mul_rsp)
    );

    gfja_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (mul_req),
        .rsp     (mul_rsp)
    );

    assign res_ready = !m_valid_reg || m_tready;

    always_comb begin
        m_valid_next = m_valid_reg;
        if (res_valid && res_ready) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid && res_ready) begin
            m_data_reg <= {res_jerk, res_acc};
            m_user_reg <= res_singular;
        end
    end

    assign m_tvalid   = m_valid_reg;
    assign m_tdata    = m_data_reg;
    assign m_tuser[0] = m_user_reg;

endmodule

FILE: tb/sv/gravity_force_jerk_accumulator_top_tb.sv
`timescale 1ns / 1ps

module gravity_force_jerk_accumulator_top_tb;

    typedef struct packed {
        gfja_pkg::func_t    func;
        logic [2:0][47:0]   pos;
        logic [2:0][47:0]   vel;
        logic [46:0]        mass;
    } body_item_t;

    typedef struct packed {
        logic [2:0][63:0]   acc;
        logic [2:0][63:0]   jerk;
        logic               singular;
    } force_sums_t;

    localparam logic signed [127:0] LIM_HI = 128'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [127:0] LIM_LO = -LIM_HI - 128'sd1;

    logic                               aclk;
    logic                               aresetn;
    logic                               s_tvalid;
    logic                               s_tready;
    logic [gfja_pkg::IN_DATA_W-1:0]     s_tdata;
    logic [0:0]                         s_tuser;
    logic                               m_tvalid;
    logic                               m_tready;
    logic [gfja_pkg::OUT_DATA_W-1:0]    m_tdata;
    logic [0:0]                         m_tuser;

    body_item_t   body_queue[$];
    force_sums_t  sums_queue[$];
    body_item_t   offered;
    int           send_gap;
    int           recv_gap;
    int           recv_hold;
    int           sums_seen;
    bit           failed;

    // predictor state
    logic signed [63:0] tgt_pos[3];
    logic signed [63:0] tgt_vel[3];
    logic [63:0]        acc_sum[3];
    logic [63:0]        jerk_sum[3];

    gravity_force_jerk_accumulator_top u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always begin
        aclk = 1'b1;
        #1;
        aclk = 1'b0;
        #1;
    end

    function automatic logic signed [127:0] wide(input logic [63:0] a);
        return {{64{a[63]}}, a};
    endfunction

    function automatic logic [63:0] sat64(input logic signed [127:0] a);
        if (a > LIM_HI) return gfja_pkg::S64_MAX;
        if (a < LIM_LO) return gfja_pkg::S64_MIN;
        return a[63:0];
    endfunction

    // times 2^e, flooring downwards and saturating upwards
    function automatic logic [63:0] pow2_scale(input logic signed [127:0] a, input int e);
        logic [63:0]        v;
        logic signed [127:0] sh;
        if (e < 0) begin
            if (-e >= 128) sh = a[127] ? -128'sd1 : 128'sd0;
            else sh = a >>> (-e);
            return sat64(sh);
        end
        v = sat64(a);
        if (e == 0 || v == 64'd0) return v;
        if (e >= 64) return v[63] ? gfja_pkg::S64_MIN : gfja_pkg::S64_MAX;
        sh = wide(v) <<< e;
        return sat64(sh);
    endfunction

    function automatic logic [63:0] sum_sat(input logic [63:0] a, input logic [63:0] b);
        return sat64(wide(a) + wide(b));
    endfunction

    function automatic void accumulate_pull(input body_item_t it);
        logic signed [63:0]  r[3];
        logic signed [63:0]  dv[3];
        logic signed [63:0]  u[3];
        logic signed [63:0]  w[3];
        logic signed [127:0] r2;
        logic signed [127:0] d;
        logic signed [127:0] mc;
        logic signed [127:0] cw;
        logic [63:0]         x, y, y2, t, f, c, uv3;
        int                  len, s, h, e;
        force_sums_t         res;
        if (it.func == gfja_pkg::FUNC_LOAD) begin
            for (int k = 0; k < 3; k++) begin
                tgt_pos[k] = 64'($signed(it.pos[k]));
                tgt_vel[k] = 64'($signed(it.vel[k]));
                acc_sum[k] = '0;
                jerk_sum[k] = '0;
            end
            return;
        end
        r2 = '0;
        for (int k = 0; k < 3; k++) begin
            r[k] = 64'($signed(it.pos[k])) - tgt_pos[k];
            dv[k] = 64'($signed(it.vel[k])) - tgt_vel[k];
            r2 = r2 + wide(r[k]) * wide(r[k]);
        end
        res.singular = (r2 == 0);
        if (!res.singular) begin
            len = 0;
            for (int b = 0; b < 128; b++) if (r2[b]) len = b + 1;
            s = (len % 2 == 1) ? len - 63 : len - 64;
            x = (s >= 0) ? 64'(r2 >>> s) : (r2[63:0] << (-s));
            h = (62 + s) / 2;
            y = x[63] ? 64'(gfja_pkg::SEED_X_HIGH) : 64'(gfja_pkg::SEED_X_LOW);
            for (int i = 0; i < gfja_pkg::RSQRT_ITERS; i++) begin
                y2 = (y * y) >> 31;
                t = ((x >> 31) * y2) >> 31;
                f = (t >= gfja_pkg::THREE_Q31) ? 64'd0 : gfja_pkg::THREE_Q31 - t;
                y = (y * f) >> 32;
            end
            c = (((y * y) >> 31) * y) >> 34;
            d = '0;
            for (int k = 0; k < 3; k++) begin
                u[k] = 64'((wide(r[k]) * $signed({64'd0, y})) >>> (h + 1));
                d = d + wide(u[k]) * wide(dv[k]);
            end
            uv3 = 64'(d >>> 30) * 64'd3;
            e = 2 * gfja_pkg::FRAC_BITS - 28 - 3 * h;
            cw = $signed({64'd0, c});
            for (int k = 0; k < 3; k++) begin
                w[k] = dv[k] - 64'((wide(uv3) * wide(u[k])) >>> 30);
                mc = $signed({81'd0, it.mass}) * wide(r[k]) * cw;
                acc_sum[k] = sum_sat(acc_sum[k], pow2_scale(mc, e));
                mc = $signed({81'd0, it.mass}) * wide(w[k]) * cw;
                jerk_sum[k] = sum_sat(jerk_sum[k], pow2_scale(mc, e));
            end
        end
        for (int k = 0; k < 3; k++) begin
            res.acc[k] = acc_sum[k];
            res.jerk[k] = jerk_sum[k];
        end
        sums_queue.push_back(res);
    endfunction

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 65) return 0;
        if (roll < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 80);
    endfunction

    // driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= '0;
            send_gap <= 0;
        end else begin
            if (s_tvalid && s_tready) accumulate_pull(offered);
            if (!s_tvalid || s_tready) begin
                if (send_gap > 0) begin
                    send_gap <= send_gap - 1;
                    s_tvalid <= 1'b0;
                end else if (body_queue.size() > 0) begin
                    offered = body_queue.pop_front();
                    s_tdata  <= {1'b0, offered.mass, offered.vel, offered.pos};
                    s_tuser  <= offered.func;
                    s_tvalid <= 1'b1;
                    send_gap <= pick_gap();
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge aclk) begin
        force_sums_t ex;
        if (!aresetn) begin
            m_tready  <= 1'b0;
            recv_gap  <= 0;
            recv_hold <= 0;
            sums_seen <= 0;
        end else begin
            if (m_tvalid && m_tready) begin
                sums_seen <= sums_seen + 1;
                if (sums_queue.size() == 0) begin
                    $display("%0t: unexpected result tdata=%h tuser=%b", $time, m_tdata, m_tuser);
                    failed = 1'b1;
                end else begin
                    ex = sums_queue.pop_front();
                    for (int k = 0; k < 3; k++) begin
                        if (m_tdata[64*k +: 64] !== ex.acc[k]) begin
                            $display("%0t: acc[%0d] expected %h actual %h",
                                     $time, k, ex.acc[k], m_tdata[64*k +: 64]);
                            failed = 1'b1;
                        end
                        if (m_tdata[192 + 64*k +: 64] !== ex.jerk[k]) begin
                            $display("%0t: jerk[%0d] expected %h actual %h",
                                     $time, k, ex.jerk[k], m_tdata[192 + 64*k +: 64]);
                            failed = 1'b1;
                        end
                    end
                    if (m_tuser[0] !== ex.singular) begin
                        $display("%0t: singular expected %b actual %b",
                                 $time, ex.singular, m_tuser[0]);
                        failed = 1'b1;
                    end
                end
            end
            // one long hold-off mid run so the block backs up into its input
            if (sums_seen == 150 && recv_hold == 0 && m_tvalid && m_tready) begin
                recv_hold <= 3000;
                m_tready  <= 1'b0;
            end else if (recv_hold > 1) begin
                recv_hold <= recv_hold - 1;
                m_tready  <= 1'b0;
            end else if (recv_gap > 0) begin
                recv_gap <= recv_gap - 1;
                m_tready <= 1'b0;
            end else begin
                if (recv_hold == 1) recv_hold <= -1;
                m_tready <= 1'b1;
                if (!m_tready || m_tvalid) recv_gap <= pick_gap();
            end
        end
    end

    function automatic logic [47:0] rnd_signed(input int bits);
        logic signed [63:0] raw;
        raw = {$urandom, $urandom};
        return 48'(raw >>> (64 - bits));
    endfunction

    function automatic body_item_t make_body(input gfja_pkg::func_t fn, input logic [47:0] px,
                                             input logic [47:0] py, input logic [47:0] pz,
                                             input logic [47:0] vx, input logic [47:0] vy,
                                             input logic [47:0] vz, input logic [46:0] m);
        body_item_t it;
        it.func = fn;
        it.pos  = {pz, py, px};
        it.vel  = {vz, vy, vx};
        it.mass = m;
        return it;
    endfunction

    initial begin
        logic [47:0] one, pmax, pmin;
        logic [46:0] mmax;
        logic [2:0][47:0] near;
        body_item_t it;
        int nb, mb, roll;
        failed = 1'b0;
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        m_tready = 1'b0;
        one  = 48'h0001_0000_0000;
        pmax = 48'h7FFF_FFFF_FFFF;
        pmin = 48'h8000_0000_0000;
        mmax = 47'h7FFF_FFFF_FFFF;
        // before any load the target sits at the origin
        body_queue.push_back(make_body(gfja_pkg::FUNC_INTERACT, 0, 0, 0, one, 0, 0, one[46:0]));
        body_queue.push_back(make_body(gfja_pkg::FUNC_INTERACT, one, 0, 0, 0, one, 0,
                                       one[46:0]));
        body_queue.push_back(make_body(gfja_pkg::FUNC_LOAD, 0, 0, 0, 0, 0, 0, mmax));
        body_queue.push_back(make_body(gfja_pkg::FUNC_INTERACT, 0, one, 0, pmax, pmin, 0,
                                       one[46:0]));
        body_queue.push_back(make_body(gfja_pkg::FUNC_INTERACT, 0, 0, -one, 0, 0, one, 0));
        body_queue.push_back(make_body(gfja_pkg::FUNC_INTERACT, 48'd1, 0, 0, 0, 0, 0, mmax));
        body_queue.push_back(make_body(gfja_pkg::FUNC_INTERACT, 0, 48'd1, 48'd1,
                                       pmax, pmax, pmax, mmax));
        body_queue.push_back(make_body(gfja_pkg::FUNC_INTERACT, -48'd1, 0, 0,
                                       pmin, pmin, pmin, mmax));
        body_queue.push_back(make_body(gfja_pkg::FUNC_LOAD, pmax, pmax, pmax,
                                       pmin, pmin, pmin, 0));
        body_queue.push_back(make_body(gfja_pkg::FUNC_INTERACT, pmin, pmin, pmin,
                                       pmax, pmax, pmax, mmax));
        body_queue.push_back(make_body(gfja_pkg::FUNC_INTERACT, pmax, pmax, pmax,
                                       0, 0, 0, mmax));
        body_queue.push_back(make_body(gfja_pkg::FUNC_INTERACT, pmin, pmax, pmin,
                                       pmax, pmin, pmax, 1));
        body_queue.push_back(make_body(gfja_pkg::FUNC_LOAD, pmin, pmin, pmin,
                                       pmax, pmax, pmax, mmax));
        body_queue.push_back(make_body(gfja_pkg::FUNC_INTERACT, pmax, pmin, pmax,
                                       pmin, pmax, pmin, mmax));
        body_queue.push_back(make_body(gfja_pkg::FUNC_INTERACT, pmin + 48'd1, pmin, pmin,
                                       0, 0, 0, mmax));
        body_queue.push_back(make_body(gfja_pkg::FUNC_LOAD, one, -one, one, one, one, -one, 0));
        body_queue.push_back(make_body(gfja_pkg::FUNC_INTERACT, one, -one, one, 0, 0, 0,
                                       one[46:0]));
        body_queue.push_back(make_body(gfja_pkg::FUNC_INTERACT, 0, 0, 0, -one, one, one,
                                       one[46:0]));
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        // let the directed part drain completely before the random part
        do @(posedge aclk); while (body_queue.size() > 0 || s_tvalid || sums_queue.size() > 0);
        near = {one, -one, one};
        for (int n = 0; n < 1200; n++) begin
            roll = $urandom_range(0, 99);
            nb = $urandom_range(2, 40);
            mb = $urandom_range(1, 47);
            if (roll < 10) begin
                it = make_body(gfja_pkg::FUNC_LOAD, rnd_signed(nb + 8), rnd_signed(nb + 8),
                               rnd_signed(nb + 8), rnd_signed(46), rnd_signed(46),
                               rnd_signed(46), 47'({$urandom, $urandom}));
                if ($urandom_range(0, 4) == 0) begin
                    it.pos = {rnd_signed(48), rnd_signed(48), rnd_signed(48)};
                    it.vel = {rnd_signed(48), rnd_signed(48), rnd_signed(48)};
                end
                near = it.pos;
            end else if (roll < 25) begin
                it = make_body(gfja_pkg::FUNC_INTERACT, rnd_signed(48), rnd_signed(48),
                               rnd_signed(48), rnd_signed(48), rnd_signed(48), rnd_signed(48),
                               47'({$urandom, $urandom}));
            end else begin
                it = make_body(gfja_pkg::FUNC_INTERACT, near[0] + rnd_signed(nb),
                               near[1] + rnd_signed(nb), near[2] + rnd_signed(nb),
                               rnd_signed($urandom_range(10, 46)),
                               rnd_signed($urandom_range(10, 46)),
                               rnd_signed($urandom_range(10, 46)),
                               47'({$urandom, $urandom} >> (64 - mb)));
                // coincident source
                if (roll < 28) it.pos = near;
            end
            body_queue.push_back(it);
        end
        do @(posedge aclk); while (body_queue.size() > 0 || s_tvalid || sums_queue.size() > 0);
        repeat (500) @(posedge aclk);
        if (!failed) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule
